>>> src/breath_burst_pause_led_assert.svh
// ----------------------------------------------------------------------------
// breath_burst_pause_led_assert
// Assertion macros shared by the RTL of the breathing LED block.
// ----------------------------------------------------------------------------
`ifndef BREATH_BURST_PAUSE_LED_ASSERT_SVH
`define BREATH_BURST_PAUSE_LED_ASSERT_SVH

// Clocked check, suppressed while reset is held.
`define BBPL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bbpl assertion failed");

// Clocked check that also holds during reset.
`define BBPL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bbpl assertion failed");

`endif

>>> src/bbpl_pkg.sv
// ----------------------------------------------------------------------------
// bbpl_pkg
// Widths, register indexes, reset values and divider handshake types for the
// burst-and-pause breathing LED generator.
// ----------------------------------------------------------------------------
package bbpl_pkg;

    localparam int LEVEL_W    = 12;
    localparam int PERIOD_W   = 16;
    localparam int REPEAT_W   = 8;
    localparam int PAUSE_W    = 16;
    localparam int ELAPSED_W  = 8;
    localparam int POS_W      = 25;
    localparam int BURST_W    = 24;
    localparam int NUM_W      = 27;   // ramp numerator: 15-bit offset * 12-bit step
    localparam int MUL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEATS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = 3'd4;

    localparam logic [LEVEL_W-1:0]  RST_LEVEL_LOW  = 12'd0;
    localparam logic [LEVEL_W-1:0]  RST_LEVEL_HIGH = 12'd4000;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd2000;
    localparam logic [REPEAT_W-1:0] RST_REPEATS    = 8'd3;
    localparam logic [PAUSE_W-1:0]  RST_PAUSE      = 16'd3000;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD = 16'd2;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [NUM_W-1:0]    quotient;
        logic [PERIOD_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> src/bbpl_div.sv
// ----------------------------------------------------------------------------
// bbpl_div
// Restoring unsigned divider, one quotient bit per cycle. A start beat loads
// the operands; done pulses when the last quotient bit is in, with quotient and remainder.
// ----------------------------------------------------------------------------
module bbpl_div
    import bbpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_count;
    logic [NUM_W-1:0]    r_quo;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;

    logic [PERIOD_W:0]   rem_sh;
    logic [PERIOD_W:0]   rem_sub;
    logic                ge;
    logic [PERIOD_W-1:0] n_rem;
    logic [NUM_W-1:0]    n_quo;
    logic                last;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
        n_rem   = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        n_quo   = {r_quo[NUM_W-2:0], ge};
        last    = (r_count == CNT_W'(NUM_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> src/breath_burst_pause_led.sv
// ----------------------------------------------------------------------------
// breath_burst_pause_led
// Burst-and-pause breathing LED level generator with triangle ramps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_elapsed_ms): one beat per time tick,
//   carrying the milliseconds since the previous tick. Each tick yields one
//   beat on the output channel (o_valid / i_stall / o_level).
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   0 level_low, 1 level_high, 2 breath_period_ms, 3 breath_repeats,
//   4 pause_ms. Write only while no tick is in flight; the new cycle length
//   applies from the next tick on.
//   On the breath ramp a tick takes two passes of the shared divider (phase
//   modulo, then ramp scaling); when the position falls in the pause or the
//   period is below MIN_PERIOD, the level is level_low and no division runs.
//   o_stall stays high while a tick is being worked, so a new tick is
//   taken in the cycle after the level loads.
//   A finished level waits in the output register; the next tick is taken
//   meanwhile and its result waits in the final state until the output frees.
//   Reset (synchronous, active low) clears the cycle position to zero,
//   restores register defaults and drops any pending output.
// ----------------------------------------------------------------------------
`include "breath_burst_pause_led_assert.svh"

module breath_burst_pause_led
    import bbpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ELAPSED_W-1:0]  i_elapsed_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LEVEL_W-1:0]    o_level,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_MUL_BURST  = 4'd1;
    localparam logic [3:0] S_WRAP       = 4'd2;
    localparam logic [3:0] S_CHECK      = 4'd3;
    localparam logic [3:0] S_MOD_START  = 4'd4;
    localparam logic [3:0] S_MOD_WAIT   = 4'd5;
    localparam logic [3:0] S_RAMP       = 4'd6;
    localparam logic [3:0] S_MUL_RAMP   = 4'd7;
    localparam logic [3:0] S_RAMP_START = 4'd8;
    localparam logic [3:0] S_RAMP_WAIT  = 4'd9;
    localparam logic [3:0] S_OUT        = 4'd10;

    logic [LEVEL_W-1:0]  r_level_low;
    logic [LEVEL_W-1:0]  r_level_high;
    logic [PERIOD_W-1:0] r_period;
    logic [REPEAT_W-1:0] r_repeats;
    logic [PAUSE_W-1:0]  r_pause;

    logic [3:0]          r_state;
    logic [POS_W:0]      r_sum;
    logic [POS_W-1:0]    r_pos;
    logic [BURST_W-1:0]  r_burst;
    logic [POS_W-1:0]    r_total;
    logic [PERIOD_W-1:0] r_phase;
    logic [MUL_W-1:0]    r_off;
    logic [PERIOD_W-1:0] r_den;
    logic [LEVEL_W-1:0]  r_mag;
    logic [LEVEL_W-1:0]  r_base;
    logic                r_neg;
    logic [NUM_W-1:0]    r_num;
    logic [LEVEL_W-1:0]  r_result;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_o_valid;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  product;
    logic [POS_W-1:0]    total;
    logic [PERIOD_W-1:0] half;
    logic                up;
    logic [LEVEL_W-1:0]  absd;
    logic [LEVEL_W-1:0]  quo;
    logic                out_load;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    bbpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier: burst length first, ramp numerator later.
    always_comb begin
        if (r_state == S_MUL_BURST) begin
            mul_a = {{(MUL_W-REPEAT_W){1'b0}}, r_repeats};
            mul_b = r_period;
        end else begin
            mul_a = r_off;
            mul_b = {{(MUL_W-LEVEL_W){1'b0}}, r_mag};
        end
        product = mul_a * mul_b;
    end

    always_comb begin
        div_req.start = (r_state == S_MOD_START) || (r_state == S_RAMP_START);
        if (r_state == S_MOD_START) begin
            div_req.dividend = {{(NUM_W-BURST_W){1'b0}}, r_pos[BURST_W-1:0]};
            div_req.divisor  = r_period;
        end else begin
            div_req.dividend = r_num;
            div_req.divisor  = r_den;
        end
    end

    always_comb begin
        total    = {1'b0, r_burst} + {{(POS_W-PAUSE_W){1'b0}}, r_pause};
        half     = r_period >> 1;
        up       = (r_level_high >= r_level_low);
        absd     = up ? (r_level_high - r_level_low) : (r_level_low - r_level_high);
        quo      = div_rsp.quotient[LEVEL_W-1:0];
        out_load = (r_state == S_OUT) && (!r_o_valid || !i_stall);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_low  <= RST_LEVEL_LOW;
            r_level_high <= RST_LEVEL_HIGH;
            r_period     <= RST_PERIOD;
            r_repeats    <= RST_REPEATS;
            r_pause      <= RST_PAUSE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEVEL_LOW:  r_level_low  <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_HIGH: r_level_high <= i_cfg_data[LEVEL_W-1:0];
                REG_PERIOD:     r_period     <= i_cfg_data[PERIOD_W-1:0];
                REG_REPEATS:    r_repeats    <= i_cfg_data[REPEAT_W-1:0];
                REG_PAUSE:      r_pause      <= i_cfg_data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MUL_BURST;
                    end
                end
                S_MUL_BURST: r_state <= S_WRAP;
                S_WRAP: begin
                    // wrap to zero once the cycle length is reached or passed
                    if (r_sum >= {1'b0, total}) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_sum[POS_W-1:0];
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_pos >= {1'b0, r_burst} || r_period < MIN_PERIOD) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MOD_START;
                    end
                end
                S_MOD_START: r_state <= S_MOD_WAIT;
                S_MOD_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_RAMP;
                    end
                end
                S_RAMP:       r_state <= S_MUL_RAMP;
                S_MUL_RAMP:   r_state <= S_RAMP_START;
                S_RAMP_START: r_state <= S_RAMP_WAIT;
                S_RAMP_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum <= {1'b0, r_pos} + {{(POS_W+1-ELAPSED_W){1'b0}}, i_elapsed_ms};
            end
            S_MUL_BURST: r_burst <= product[BURST_W-1:0];
            S_WRAP:      r_total <= total;
            S_CHECK:     r_result <= r_level_low;
            S_MOD_WAIT: begin
                if (div_rsp.done) begin
                    r_phase <= div_rsp.remainder;
                end
            end
            S_RAMP: begin
                r_mag <= absd;
                if (r_phase <= half) begin
                    r_off  <= r_phase;
                    r_den  <= half;
                    r_base <= r_level_low;
                    r_neg  <= !up;
                end else begin
                    r_off  <= r_phase - half;
                    r_den  <= r_period - half;
                    r_base <= r_level_high;
                    r_neg  <= up;
                end
            end
            S_MUL_RAMP: r_num <= product[NUM_W-1:0];
            S_RAMP_WAIT: begin
                if (div_rsp.done) begin
                    r_result <= r_neg ? (r_base - quo) : (r_base + quo);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_level <= r_result;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_level     = r_level;
    assign o_cfg_ready = 1'b1;

    `BBPL_ASSERT(a_pos_in_cycle, i_clk, i_rst_n,
                 (r_state == S_CHECK) |-> (r_pos < r_total || r_pos == '0))
    `BBPL_ASSERT(a_phase_below_period, i_clk, i_rst_n, (r_state == S_RAMP) |-> (r_phase < r_period))
    `BBPL_ASSERT(a_valid_from_out, i_clk, i_rst_n, $rose(r_o_valid) |-> $past(r_state == S_OUT))
    `BBPL_ASSERT(a_div_idle_on_start, i_clk, i_rst_n, div_req.start |-> !div_rsp.busy)
    `BBPL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_o_valid))

endmodule
